/* src/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer wheel package
// Shared field widths, stream layout, action codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int unsigned TimersDef = 16;
  localparam int unsigned SlotsDef  = 10;

  localparam int unsigned ActW = 2;
  localparam int unsigned IdW  = 4;
  localparam int unsigned PerW = 16;
  localparam int unsigned PerMax = (1 << PerW) - 1;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [ActW-1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2
  } action_e;

  typedef struct packed {
    logic take_in;
    logic adv_pos;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic add_write;
    logic del_clear;
    logic emit_pend_last;
    logic emit_null;
  } ptw_cmd_t;

  typedef struct packed {
    action_e act;
    logic    scan_last;
    logic    push_need;
    logic    out_free;
    logic    pend_valid;
    logic    div_done;
  } ptw_sts_t;

endpackage

/* src/ptw_div.sv */
// ----------------------------------------------------------------------------
// Period divider
// Division of a 16-bit value by the constant wheel size through a multiply
// with the scaled reciprocal, in registered steps: capture, quotient, remainder.
// ----------------------------------------------------------------------------
module ptw_div
  import ptw_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [PerW-1:0]            dividend_i,
  output logic                       done_o,
  output logic [PerW-1:0]            quot_o,
  output logic [$clog2(SLOTS)-1:0]   rem_o
);

  localparam int unsigned     PosW  = $clog2(SLOTS);
  localparam int unsigned     Shift = PerW + PosW;
  localparam int unsigned     ProdW = Shift + PerW;
  localparam longint unsigned Recip = ((64'd1 << Shift) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  logic              num_v_q;
  logic              quot_v_q;
  logic              done_q;
  logic [PerW-1:0]   num_q;
  logic [PerW-1:0]   quot_q, quot_d;
  logic [PosW-1:0]   rem_q, rem_d;
  logic [ProdW-1:0]  prod;
  logic [PerW-1:0]   back;

  assign prod   = ProdW'(num_q) * ProdW'(Recip);
  assign quot_d = prod[Shift +: PerW];
  assign back   = quot_q * PerW'(SLOTS);
  assign rem_d  = PosW'(num_q - back);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q  <= 1'b0;
      quot_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      num_v_q  <= start_i;
      quot_v_q <= num_v_q;
      done_q   <= quot_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (num_v_q) begin
      quot_q <= quot_d;
    end
    if (quot_v_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

/* src/ptw_dp.sv */
// ----------------------------------------------------------------------------
// Periodic timer wheel datapath
// Timer store, armed flags, wheel position, scan index, pending firing
// and the output register.
// ----------------------------------------------------------------------------
module ptw_dp
  import ptw_pkg::*;
#(
  parameter int unsigned TIMERS = TimersDef,
  parameter int unsigned SLOTS  = SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptw_cmd_t            cmd_i,
  output ptw_sts_t            sts_o,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [ActW-1:0]     s_tuser_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tuser_o,
  output logic                m_tlast_o
);

  localparam int unsigned IdxW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned PosW = $clog2(SLOTS);
  localparam int unsigned RndW = $clog2((PerMax - 1) / SLOTS + 1);

  typedef struct packed {
    logic [RndW-1:0] rounds;
    logic [RndW-1:0] init;
    logic [PosW-1:0] slot;
    logic [PosW-1:0] step;
  } entry_t;

  function automatic logic [PosW-1:0] wrap_add(input logic [PosW-1:0] a,
                                               input logic [PosW-1:0] b);
    logic [PosW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PosW+1)'(SLOTS)) begin
      sum = sum - (PosW+1)'(SLOTS);
    end
    return sum[PosW-1:0];
  endfunction

  entry_t            mem_q [TIMERS];
  entry_t            rd_q;
  entry_t            wr_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [IdxW-1:0]   rd_addr;

  logic [TIMERS-1:0] armed_q;
  logic [PosW-1:0]   pos_q;
  logic [IdxW-1:0]   idx_q, idx_next;

  action_e           act_q;
  logic [IdW-1:0]    id_q;
  logic [PerW-1:0]   per_q;
  logic [IdxW-1:0]   id_idx;
  logic              id_ok;

  logic              pend_v_q;
  logic [IdW-1:0]    pend_id_q;

  logic              out_v_q;
  logic              out_fired_q;
  logic [IdW-1:0]    out_id_q;
  logic              out_last_q;
  logic              out_free;

  logic              hit, fire;
  logic              div_done;
  logic [PerW-1:0]   div_quot;
  logic [PosW-1:0]   div_rem;
  logic [PosW-1:0]   add_step;
  logic [RndW-1:0]   add_rounds;

  ptw_div #(.SLOTS(SLOTS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (per_q - 1'b1),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign id_idx = IdxW'(id_q);
  assign id_ok  = 32'(id_q) < TIMERS;

  assign idx_next = (idx_q == IdxW'(TIMERS - 1)) ? '0 : idx_q + 1'b1;
  assign rd_addr  = cmd_i.scan_start ? '0 : (cmd_i.scan_step ? idx_next : idx_q);

  assign hit  = armed_q[idx_q] && (rd_q.slot == pos_q);
  assign fire = hit && (rd_q.rounds == '0);

  assign add_step   = ((per_q == '0) || (div_rem == PosW'(SLOTS - 1))) ? '0 :
                      div_rem + 1'b1;
  assign add_rounds = (per_q == '0) ? '0 : RndW'(div_quot);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_q;
    if (cmd_i.add_write) begin
      wr_en          = id_ok;
      wr_addr        = id_idx;
      wr_data.rounds = add_rounds;
      wr_data.init   = add_rounds;
      wr_data.step   = add_step;
      wr_data.slot   = wrap_add(pos_q, add_step);
    end else if (cmd_i.scan_step && hit) begin
      wr_en = 1'b1;
      if (fire) begin
        wr_data.rounds = rd_q.init;
        wr_data.slot   = wrap_add(rd_q.slot, rd_q.step);
      end else begin
        wr_data.rounds = rd_q.rounds - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
    if (cmd_i.take_in) begin
      act_q <= action_e'(s_tuser_i);
      id_q  <= s_tdata_i[IdW-1:0];
      per_q <= s_tdata_i[IdW+PerW-1:IdW];
    end
  end

  assign out_free = !out_v_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      pend_v_q    <= 1'b0;
      pend_id_q   <= '0;
      out_v_q     <= 1'b0;
      out_fired_q <= 1'b0;
      out_id_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cmd_i.add_write && id_ok) begin
        armed_q[id_idx] <= 1'b1;
      end
      if (cmd_i.del_clear && id_ok) begin
        armed_q[id_idx] <= 1'b0;
      end
      if (cmd_i.adv_pos) begin
        pos_q <= (pos_q == PosW'(SLOTS - 1)) ? '0 : pos_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q    <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_next;
        if (fire) begin
          pend_v_q  <= 1'b1;
          pend_id_q <= IdW'(idx_q);
        end
      end else if (cmd_i.emit_pend_last) begin
        pend_v_q <= 1'b0;
      end

      if (cmd_i.scan_step && fire && pend_v_q) begin
        out_v_q     <= 1'b1;
        out_fired_q <= 1'b1;
        out_id_q    <= pend_id_q;
        out_last_q  <= 1'b0;
      end else if (cmd_i.emit_pend_last) begin
        out_v_q     <= 1'b1;
        out_fired_q <= 1'b1;
        out_id_q    <= pend_id_q;
        out_last_q  <= 1'b1;
      end else if (cmd_i.emit_null) begin
        out_v_q     <= 1'b1;
        out_fired_q <= 1'b0;
        out_id_q    <= '0;
        out_last_q  <= 1'b1;
      end else if (m_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign sts_o.act        = act_q;
  assign sts_o.scan_last  = idx_q == IdxW'(TIMERS - 1);
  assign sts_o.push_need  = fire && pend_v_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_v_q;
  assign sts_o.div_done   = div_done;

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = OutDataW'(out_id_q);
  assign m_tuser_o  = out_fired_q;
  assign m_tlast_o  = out_last_q;

  // A firing that displaces the pending one must find the output register free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step && fire && pend_v_q |-> out_free)
    else $error("ptw_dp: firing pushed into a busy output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_start |=> !pend_v_q && (idx_q == '0))
    else $error("ptw_dp: scan did not start clean");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.add_write && cmd_i.scan_step))
    else $error("ptw_dp: store written by add and scan at once");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < SLOTS)
    else $error("ptw_dp: wheel position out of range");

endmodule

/* src/ptw_ctrl.sv */
// ----------------------------------------------------------------------------
// Periodic timer wheel controller
// Sequences input capture, the tick scan, the add division, the delete and
// the result pushes into the output register.
// ----------------------------------------------------------------------------
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  ptw_sts_t sts_i,
  output ptw_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_FINISH,
    ST_DIV,
    ST_ADDW,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take_in = s_tvalid_i;
        if (s_tvalid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.act)
          ACT_TICK: begin
            cmd_o.adv_pos    = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          ACT_ADD: begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
          ACT_DEL: begin
            cmd_o.del_clear = 1'b1;
            state_d         = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        if (!sts_i.push_need || sts_i.out_free) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_pend_last = sts_i.pend_valid;
          cmd_o.emit_null      = !sts_i.pend_valid;
          state_d              = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_ADDW;
        end
      end
      ST_ADDW: begin
        cmd_o.add_write = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_null = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = state_q == ST_IDLE;

endmodule

/* src/periodic_timer_wheel.sv */
// ----------------------------------------------------------------------------
// Periodic timer wheel
// Hashed timing wheel of SLOTS positions serving TIMERS periodic timers.
//
// The slave channel takes one item at a time: tuser carries the action (tick,
// add, delete), tdata the timer id and the period. The master channel gives
// the results of each item, the last one marked by tlast; tuser flags a fired
// timer, tdata holds its id. Fired timers of a tick come in ascending id order;
// any other item, or a tick where nothing fires, gives one result with the
// fired flag low.
// A tick decodes and advances the wheel, reads each timer entry from the
// timer store in turn, then pushes the final result. An add passes through
// the period divider before its entry is written; a delete clears the armed
// flag of its timer. The next item is taken in the cycle after the previous
// one has pushed its last result, even while that result still waits in the
// output register. When the receiver stalls, a tick scan holds at a firing
// that finds another already pending until the output register frees.
// Reset disarms all timers and sets the wheel to 0.
// ----------------------------------------------------------------------------
module periodic_timer_wheel
  import ptw_pkg::*;
#(
  parameter int unsigned TIMERS = TimersDef,
  parameter int unsigned SLOTS  = SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // timer_id, period
  input  logic [ActW-1:0]     s_axis_tuser,   // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // fired_id
  output logic                m_axis_tuser,   // fired
  output logic                m_axis_tlast
);

  ptw_cmd_t cmd;
  ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptw_dp #(
    .TIMERS (TIMERS),
    .SLOTS  (SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

/* verif/tb_periodic_timer_wheel.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer wheel testbench
// Drives tick, add, delete and unused items into the wheel through a table of
// directed items and then random phases with varying idle rates on both
// streams. An in-bench predictor of the wheel works out the results of every
// item, and each result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_periodic_timer_wheel;
  import ptw_pkg::*;

  localparam int unsigned Timers      = TimersDef;
  localparam int unsigned Slots       = SlotsDef;
  localparam logic [ActW-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned DirItems    = 25;
  localparam int unsigned MaxPrints   = 20;

  typedef struct packed {
    logic           fired;
    logic [IdW-1:0] id;
    logic           last;
  } wheel_res_t;

  typedef struct packed {
    logic [ActW-1:0] act;
    logic [IdW-1:0]  id;
    logic [PerW-1:0] per;
    logic            idle_only;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [ActW-1:0]     s_axis_tuser  = ACT_TICK;
  logic                m_axis_tready = 1'b0;
  wire                 s_axis_tready;
  wire                 m_axis_tvalid;
  wire [OutDataW-1:0]  m_axis_tdata;
  wire                 m_axis_tuser;
  wire                 m_axis_tlast;

  int unsigned     wheel_pos;
  logic            armed      [Timers];
  logic [PerW-1:0] per_tab    [Timers];
  int unsigned     slot_tab   [Timers];
  int unsigned     rounds_tab [Timers];
  wheel_res_t      step_res   [$];
  wheel_res_t      pending_q  [$];
  stim_row_t       dir_tab    [DirItems];

  int          err_cnt   = 0;
  int          n_tick    = 0;
  int          n_add     = 0;
  int          n_del     = 0;
  int          n_unused  = 0;
  int          n_results = 0;
  int          n_fired   = 0;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 63;
  int          hold_seq  = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int unsigned cyc       = 0;

  periodic_timer_wheel #(
    .TIMERS(Timers),
    .SLOTS (Slots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    err_cnt++;
    if (err_cnt <= MaxPrints) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  function automatic void arm_timer_entry(int unsigned idx, logic [PerW-1:0] per);
    per_tab[idx]    = per;
    slot_tab[idx]   = (wheel_pos + per) % Slots;
    rounds_tab[idx] = (per == 0) ? 0 : (per - 1) / Slots;
    armed[idx]      = 1'b1;
  endfunction

  function automatic void predict_wheel_item(logic [ActW-1:0] act, logic [IdW-1:0] id,
                                             logic [PerW-1:0] per);
    step_res.delete();
    case (act)
      ACT_TICK: begin
        n_tick++;
        wheel_pos = (wheel_pos + 1) % Slots;
        for (int i = 0; i < Timers; i++) begin
          if (armed[i] && slot_tab[i] == wheel_pos) begin
            if (rounds_tab[i] == 0) begin
              arm_timer_entry(i, per_tab[i]);
              step_res.insert(step_res.size(), '{1'b1, IdW'(i), 1'b0});
            end else begin
              rounds_tab[i]--;
            end
          end
        end
      end
      ACT_ADD: begin
        n_add++;
        if (id < Timers) arm_timer_entry(id, per);
      end
      ACT_DEL: begin
        n_del++;
        if (id < Timers) armed[id] = 1'b0;
      end
      default: n_unused++;
    endcase
    if (step_res.size() == 0) begin
      step_res.insert(0, '{1'b0, {IdW{1'b0}}, 1'b1});
    end else begin
      step_res[step_res.size() - 1].last = 1'b1;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic [ActW-1:0] act, logic [IdW-1:0] id,
                           logic [PerW-1:0] per, logic idle_only);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {{(InDataW - IdW - PerW){1'b0}}, per, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_wheel_item(act, id, per);
    if (idle_only) begin
      pending_q.insert(pending_q.size(), '{1'b0, {IdW{1'b0}}, 1'b1});
    end else begin
      foreach (step_res[k]) pending_q.insert(pending_q.size(), step_res[k]);
    end
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    wheel_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser) n_fired++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, fired_id", 0, m_axis_tdata);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tuser !== want.fired) report_mismatch("fired", want.fired, m_axis_tuser);
        if (m_axis_tdata !== OutDataW'(want.id)) begin
          report_mismatch("fired_id", want.id, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) report_mismatch("last", want.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cyc, pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ActW-1:0] act;
    logic [IdW-1:0]  id;
    logic [PerW-1:0] per;
    int unsigned     r;

    dir_tab[0]  = '{ACT_TICK,   4'd0,  16'd0,     1'b1};
    dir_tab[1]  = '{ACT_DEL,    4'd3,  16'd0,     1'b1};
    dir_tab[2]  = '{ACT_UNUSED, 4'd15, 16'hFFFF,  1'b1};
    dir_tab[3]  = '{ACT_ADD,    4'd0,  16'd1,     1'b1};
    dir_tab[4]  = '{ACT_ADD,    4'd15, 16'hFFFF,  1'b1};
    dir_tab[5]  = '{ACT_TICK,   4'd0,  16'd0,     1'b0};
    dir_tab[6]  = '{ACT_ADD,    4'd5,  16'd0,     1'b1};
    dir_tab[7]  = '{ACT_ADD,    4'd7,  16'd10,    1'b1};
    dir_tab[8]  = '{ACT_ADD,    4'd9,  16'd3,     1'b1};
    dir_tab[9]  = '{ACT_ADD,    4'd3,  16'd3,     1'b1};
    dir_tab[10] = '{ACT_ADD,    4'd0,  16'd2,     1'b1};
    for (int k = 11; k <= 20; k++) dir_tab[k] = '{ACT_TICK, 4'd0, 16'd0, 1'b0};
    dir_tab[21] = '{ACT_DEL,    4'd5,  16'd0,     1'b1};
    dir_tab[22] = '{ACT_DEL,    4'd15, 16'd0,     1'b1};
    dir_tab[23] = '{ACT_TICK,   4'd0,  16'd0,     1'b0};
    dir_tab[24] = '{ACT_ADD,    4'd12, 16'd20,    1'b1};

    wheel_pos = 0;
    for (int i = 0; i < Timers; i++) armed[i] = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].act, dir_tab[k].id, dir_tab[k].per, dir_tab[k].idle_only);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 63 : 0;
      recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 7 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 40) hold_seq++;
        if (n == 70) begin
          // Arm every timer on the same slot so that one tick fires them all.
          for (int i = 0; i < Timers; i++) send_item(ACT_ADD, IdW'(i), 16'd7, 1'b0);
          repeat (7) send_item(ACT_TICK, {IdW{1'b0}}, {PerW{1'b0}}, 1'b0);
        end
        r = $urandom_range(99);
        if (r < 55) act = ACT_TICK;
        else if (r < 85) act = ACT_ADD;
        else if (r < 96) act = ACT_DEL;
        else act = ACT_UNUSED;
        id = IdW'($urandom_range(Timers - 1));
        r = $urandom_range(99);
        if (r < 3) per = '0;
        else if (r < 55) per = PerW'($urandom_range(25, 1));
        else if (r < 82) per = PerW'($urandom_range(120, 26));
        else if (r < 92) per = PerW'($urandom_range(1000, 121));
        else per = PerW'($urandom_range(PerMax));
        send_item(act, id, per, 1'b0);
      end
      s_axis_tvalid = 1'b0;
      while (pending_q.size() != 0) @(negedge clk_i);
    end

    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d ticks, %0d adds, %0d deletes and %0d unused actions.",
             n_tick, n_add, n_del, n_unused);
    $display("Checked %0d results, %0d of them fired timers.", n_results, n_fired);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
src/ptw_pkg.sv
src/ptw_div.sv
src/ptw_dp.sv
src/ptw_ctrl.sv
src/periodic_timer_wheel.sv
verif/tb_periodic_timer_wheel.sv
